/* rtl/core/bimode_branch_predictor_assert.svh */
// Assertion macros for the bi-mode branch predictor.
// Assertions become empty when SYNTHESIS is defined; needs no other file.
`ifndef BIMODE_BRANCH_PREDICTOR_ASSERT_SVH
`define BIMODE_BRANCH_PREDICTOR_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property at every rising edge, off while reset is low.
`define BBP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bimode_branch_predictor: assertion failed");
// Check a property at every rising edge, reset included.
`define BBP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bimode_branch_predictor: assertion failed");
`else
`define BBP_ASSERT(label, clk, rst_n, prop)
`define BBP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* rtl/core/bbp_pkg.sv */
// Shared constants, item kinds and a counter helper of the bi-mode predictor.
// No dependencies.
package bbp_pkg;

    localparam int CHOICE_ENTRIES_DEF  = 4096;
    localparam int GLOBAL_ENTRIES_DEF  = 4096;
    localparam int CHOICE_CTR_BITS_DEF = 2;
    localparam int GLOBAL_CTR_BITS_DEF = 2;

    localparam int ADDR_W     = 32;
    localparam int KIND_W     = 3;
    localparam int HIST_PORT_W = 12;
    localparam int SHIFT_W    = 4;
    localparam int CTR_MAX_W  = 8;

    localparam logic [SHIFT_W-1:0] INST_SHIFT_RESET = 4'd2;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UNCOND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SQUASH = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BTB    = 3'd4;

    // Step a saturating counter one count toward the outcome.
    function automatic logic [CTR_MAX_W-1:0] sat_step(input logic [CTR_MAX_W-1:0] c,
                                                      input logic up,
                                                      input logic [CTR_MAX_W-1:0] maxv);
        logic [CTR_MAX_W-1:0] r;
        r = c;
        if (up) begin
            if (c < maxv) r = c + 8'd1;
        end else begin
            if (c != '0) r = c - 8'd1;
        end
        return r;
    endfunction

endpackage

/* rtl/core/bbp_ctr_ram.sv */
// Counter table: synchronous RAM, one write and one registered read port.
// Depends on nothing but its parameters.
module bbp_ctr_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the read word until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bimode_branch_predictor.sv */
// Bi-mode branch direction predictor, top level: control, history, result register.
// Depends on bbp_pkg, bbp_ctr_ram and bimode_branch_predictor_assert.svh.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------------
//  input     | i_in_valid / o_in_stall   | i_kind .. i_ckpt_valid_in
//  output    | o_out_valid / i_out_stall | o_prediction .. o_ckpt_valid
//  config    | i_cfg_we                  | i_cfg_wdata (inst_shift)
//
// For an item, the accepting edge reads the two counter RAMs; the evaluate step then
// computes, writes the trained counters back and loads the result register.
// After reset a clearing pass zeroes the tables, walking every index of the
// larger table; no word is accepted then, config writes are.
// A stalled result waits in the output register; the item behind it holds in the
// evaluate step, with its read words held, until the register frees.
`include "bimode_branch_predictor_assert.svh"

module bimode_branch_predictor
    import bbp_pkg::*;
#(
    parameter int CHOICE_ENTRIES  = CHOICE_ENTRIES_DEF,
    parameter int GLOBAL_ENTRIES  = GLOBAL_ENTRIES_DEF,
    parameter int CHOICE_CTR_BITS = CHOICE_CTR_BITS_DEF,
    parameter int GLOBAL_CTR_BITS = GLOBAL_CTR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [SHIFT_W-1:0]     i_cfg_wdata,
    // input words
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [ADDR_W-1:0]      i_branch_addr,
    input  logic                   i_taken,
    input  logic                   i_was_squashed,
    input  logic [HIST_PORT_W-1:0] i_ckpt_history_in,
    input  logic                   i_ckpt_taken_used_in,
    input  logic                   i_ckpt_final_in,
    input  logic                   i_ckpt_valid_in,
    // result words
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_prediction,
    output logic [HIST_PORT_W-1:0] o_ckpt_history,
    output logic                   o_ckpt_taken_used,
    output logic                   o_ckpt_taken_pred,
    output logic                   o_ckpt_not_taken_pred,
    output logic                   o_ckpt_valid
);

    localparam int CI_W  = $clog2(CHOICE_ENTRIES);
    localparam int HW    = $clog2(GLOBAL_ENTRIES);  // history width = global index width
    localparam int CLR_W = (CI_W > HW) ? CI_W : HW;
    localparam int GP_W  = 2 * GLOBAL_CTR_BITS;     // taken and not-taken counter pair

    localparam logic [CTR_MAX_W-1:0] C_MAX = CTR_MAX_W'((1 << CHOICE_CTR_BITS) - 1);
    localparam logic [CTR_MAX_W-1:0] G_MAX = CTR_MAX_W'((1 << GLOBAL_CTR_BITS) - 1);
    localparam logic [CTR_MAX_W-1:0] C_THR = CTR_MAX_W'((1 << (CHOICE_CTR_BITS - 1)) - 1);
    localparam logic [CTR_MAX_W-1:0] G_THR = CTR_MAX_W'((1 << (GLOBAL_CTR_BITS - 1)) - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    t_state r_state;
    logic [CLR_W-1:0] r_clr;
    logic [SHIFT_W-1:0] r_inst_shift;
    logic [HW-1:0] r_hist, n_hist;

    // held item
    logic [KIND_W-1:0]      r_kind;
    logic                   r_taken;
    logic                   r_squashed;
    logic [HIST_PORT_W-1:0] r_ckh;
    logic                   r_used_in;
    logic                   r_final_in;
    logic                   r_valid_in;
    logic [CI_W-1:0]        r_cidx;
    logic [HW-1:0]          r_gidx;

    // result register
    logic                   r_out_valid;
    logic                   r_pred;
    logic [HIST_PORT_W-1:0] r_out_hist;
    logic                   r_used;
    logic                   r_tp;
    logic                   r_ntp;
    logic                   r_valid;

    logic                   n_pred, n_used, n_tp, n_ntp, n_valid, n_train;
    logic [HIST_PORT_W-1:0] n_out_hist;

    // ---------------------------------------------------------------
    // Index generation on the accepting edge.
    // ---------------------------------------------------------------
    logic                        w_in_acc;
    logic [ADDR_W-1:0]           w_sa;
    logic [HW+HIST_PORT_W-1:0]   w_ckh_in_wide;
    logic [HW-1:0]               w_ckh_in;
    logic [HW-1:0]               w_hsel;
    logic [CI_W-1:0]             w_cidx;
    logic [HW-1:0]               w_gidx;

    assign o_in_stall    = (r_state != S_IDLE);
    assign w_in_acc      = i_in_valid && !o_in_stall;
    assign w_sa          = i_branch_addr >> r_inst_shift;
    assign w_ckh_in_wide = {{HW{1'b0}}, i_ckpt_history_in};
    assign w_ckh_in      = w_ckh_in_wide[HW-1:0];
    // Lookup hashes with the live history, every other kind with the checkpointed one.
    assign w_hsel        = (i_kind == KIND_LOOKUP) ? r_hist : w_ckh_in;
    assign w_cidx        = w_sa[CI_W-1:0];
    assign w_gidx        = w_sa[HW-1:0] ^ w_hsel;

    // ---------------------------------------------------------------
    // Counter tables: the choice RAM, and one RAM whose word holds the
    // taken counter above the not-taken counter of the same index.
    // ---------------------------------------------------------------
    logic                       w_clearing, w_done;
    logic                       w_c_we, w_g_we;
    logic [CHOICE_CTR_BITS-1:0] w_c_rd, w_c_wd;
    logic [GP_W-1:0]            w_g_rd, w_g_wd;
    logic [GLOBAL_CTR_BITS-1:0] w_t_rd, w_n_rd, w_t_wd, w_n_wd;
    logic [CI_W-1:0]            w_c_waddr;
    logic [HW-1:0]              w_g_waddr;

    bbp_ctr_ram #(.DEPTH(CHOICE_ENTRIES), .WIDTH(CHOICE_CTR_BITS)) u_choice (
        .i_clk   (i_clk),
        .i_re    (w_in_acc),
        .i_raddr (w_cidx),
        .o_rdata (w_c_rd),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wd)
    );

    bbp_ctr_ram #(.DEPTH(GLOBAL_ENTRIES), .WIDTH(GP_W)) u_global (
        .i_clk   (i_clk),
        .i_re    (w_in_acc),
        .i_raddr (w_gidx),
        .o_rdata (w_g_rd),
        .i_we    (w_g_we),
        .i_waddr (w_g_waddr),
        .i_wdata (w_g_wd)
    );

    assign w_t_rd = w_g_rd[GP_W-1:GLOBAL_CTR_BITS];
    assign w_n_rd = w_g_rd[GLOBAL_CTR_BITS-1:0];

    // ---------------------------------------------------------------
    // Evaluate step: predictions, history and checkpoint.
    // ---------------------------------------------------------------
    logic                      w_ch, w_t, w_n, w_fin;
    logic [HW+HIST_PORT_W-1:0] w_ckh_wide;
    logic [HW-1:0]             w_ckh;
    logic [HW+HIST_PORT_W-1:0] w_hist_wide;
    logic [HIST_PORT_W-1:0]    w_hist_out;
    logic                      w_choice_train;

    assign w_ch  = CTR_MAX_W'(w_c_rd) > C_THR;
    assign w_t   = CTR_MAX_W'(w_t_rd) > G_THR;
    assign w_n   = CTR_MAX_W'(w_n_rd) > G_THR;
    assign w_fin = w_ch ? w_t : w_n;

    assign w_ckh_wide  = {{HW{1'b0}}, r_ckh};
    assign w_ckh       = w_ckh_wide[HW-1:0];
    assign w_hist_wide = {{HIST_PORT_W{1'b0}}, r_hist};
    assign w_hist_out  = w_hist_wide[HIST_PORT_W-1:0];

    always_comb begin
        n_pred     = r_final_in;
        n_out_hist = r_ckh;
        n_used     = r_used_in;
        n_tp       = 1'b0;
        n_ntp      = 1'b0;
        n_valid    = r_valid_in;
        n_hist     = r_hist;
        n_train    = 1'b0;
        unique case (r_kind)
            KIND_LOOKUP: begin
                n_pred     = w_fin;
                n_out_hist = w_hist_out;
                n_used     = w_ch;
                n_tp       = w_t;
                n_ntp      = w_n;
                n_valid    = 1'b1;
                n_hist     = {r_hist[HW-2:0], w_fin};
            end
            KIND_UNCOND: begin
                n_pred     = 1'b1;
                n_out_hist = w_hist_out;
                n_used     = 1'b1;
                n_tp       = 1'b1;
                n_ntp      = 1'b1;
                n_valid    = 1'b1;
                n_hist     = {r_hist[HW-2:0], 1'b1};
            end
            KIND_UPDATE: begin
                n_valid = 1'b0;
                if (r_valid_in) begin
                    n_train = 1'b1;
                    // A squashed update rebuilds history from the checkpoint.
                    if (r_squashed) begin
                        n_hist  = {w_ckh[HW-2:0], r_taken};
                        n_valid = 1'b1;
                    end
                end
            end
            KIND_SQUASH: begin
                n_hist  = w_ckh;
                n_valid = 1'b0;
            end
            KIND_BTB: begin
                n_hist = {r_hist[HW-1:1], 1'b0};
            end
            default: begin
            end
        endcase
    end

    // Skip the choice update when the final guess was right but overrode the choice.
    assign w_choice_train = (r_final_in != r_taken) || (r_final_in == r_used_in);

    assign w_clearing = (r_state == S_CLEAR);
    assign w_done     = (r_state == S_EVAL) && (!r_out_valid || !i_out_stall);

    assign w_c_we = w_clearing || (w_done && n_train && w_choice_train);
    assign w_g_we = w_clearing || (w_done && n_train);

    assign w_c_waddr = w_clearing ? r_clr[CI_W-1:0] : r_cidx;
    assign w_g_waddr = w_clearing ? r_clr[HW-1:0]   : r_gidx;

    assign w_c_wd = w_clearing ? '0 :
        CHOICE_CTR_BITS'(sat_step(CTR_MAX_W'(w_c_rd), r_taken, C_MAX));
    // Train the selected half, write the other half back as read.
    assign w_t_wd = w_clearing ? '0 :
        r_used_in ? GLOBAL_CTR_BITS'(sat_step(CTR_MAX_W'(w_t_rd), r_taken, G_MAX)) : w_t_rd;
    assign w_n_wd = w_clearing ? '0 :
        !r_used_in ? GLOBAL_CTR_BITS'(sat_step(CTR_MAX_W'(w_n_rd), r_taken, G_MAX)) : w_n_rd;
    assign w_g_wd = {w_t_wd, w_n_wd};

    // ---------------------------------------------------------------
    // Sequencer, history, held item and result register.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_inst_shift <= INST_SHIFT_RESET;
            r_hist       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_inst_shift <= i_cfg_wdata;
            end

            // Raise on a finished item, drop once the consumer takes the word.
            r_out_valid <= w_done || (r_out_valid && i_out_stall);

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_done) begin
                        r_state <= S_IDLE;
                        r_hist  <= n_hist;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind     <= i_kind;
            r_taken    <= i_taken;
            r_squashed <= i_was_squashed;
            r_ckh      <= i_ckpt_history_in;
            r_used_in  <= i_ckpt_taken_used_in;
            r_final_in <= i_ckpt_final_in;
            r_valid_in <= i_ckpt_valid_in;
            r_cidx     <= w_cidx;
            r_gidx     <= w_gidx;
        end
        if (w_done) begin
            r_pred     <= n_pred;
            r_out_hist <= n_out_hist;
            r_used     <= n_used;
            r_tp       <= n_tp;
            r_ntp      <= n_ntp;
            r_valid    <= n_valid;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_prediction          = r_pred;
    assign o_ckpt_history        = r_out_hist;
    assign o_ckpt_taken_used     = r_used;
    assign o_ckpt_taken_pred     = r_tp;
    assign o_ckpt_not_taken_pred = r_ntp;
    assign o_ckpt_valid          = r_valid;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `BBP_ASSERT(a_acc_to_eval, i_clk, i_rst_n, w_in_acc |=> (r_state == S_EVAL))
    `BBP_ASSERT(a_rose_after_eval, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_EVAL))
    `BBP_ASSERT(a_hist_only_on_done, i_clk, i_rst_n, !w_done |=> $stable(r_hist))
    `BBP_ASSERT(a_no_write_idle, i_clk, i_rst_n, (r_state == S_IDLE) |-> !(w_c_we || w_g_we))

endmodule
